>>> hdl/pvg_pkg.sv
// ----------------------------------------------------------------------------
// pvg_pkg: shared types and constants of the point visibility gate
// angle table, gain constant and configuration register indexes
// ----------------------------------------------------------------------------
package pvg_pkg;

  // register indexes of the configuration port
  localparam logic [1:0] REG_MAX_RANGE_SQ = 2'd0;
  localparam logic [1:0] REG_MIN_RANGE_SQ = 2'd1;
  localparam logic [1:0] REG_FOV_ANGLE    = 2'd2;

  localparam int TABLE_LEN = 24;
  localparam int GUARD_BITS = 8;
  // 1/K of the cordic gain, Q.20
  localparam logic signed [20:0] INV_GAIN_Q20 = 21'sd636751;
  localparam logic [62:0] RANGE_SAT = {63{1'b1}};

  typedef logic [31:0] bangle_t;

  // arctangent of 2^-i as 32 bit binary angle
  function automatic bangle_t atan_lut(input int i);
    bangle_t v;
    case (i)
      0:  v = 32'h20000000;  1: v = 32'h12E4051E;  2: v = 32'h09FB385B;
      3:  v = 32'h051111D4;  4: v = 32'h028B0D43;  5: v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;  7: v = 32'h00517C55;  8: v = 32'h0028BE53;
      9:  v = 32'h00145F2F; 10: v = 32'h000A2F98; 11: v = 32'h000517CC;
      12: v = 32'h00028BE6; 13: v = 32'h000145F3; 14: v = 32'h0000A2FA;
      15: v = 32'h0000517D; 16: v = 32'h000028BE; 17: v = 32'h0000145F;
      18: v = 32'h00000A30; 19: v = 32'h00000518; 20: v = 32'h0000028C;
      21: v = 32'h00000146; 22: v = 32'h000000A3; 23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

>>> hdl/pvg_if.sv
// ----------------------------------------------------------------------------
// pvg_if: request channels of the point visibility gate
// input channel with pose and point, result channel with visibility
// ----------------------------------------------------------------------------
interface pvg_in_if;
  logic               valid;
  logic               ready;
  logic               pose_valid;
  logic signed [31:0] robot_x;
  logic signed [31:0] robot_y;
  logic signed [15:0] robot_heading;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;

  modport source (output valid, pose_valid, robot_x, robot_y, robot_heading,
                  point_x, point_y, input ready);
  modport sink (input valid, pose_valid, robot_x, robot_y, robot_heading,
                point_x, point_y, output ready);
endinterface

interface pvg_out_if;
  logic               valid;
  logic               ready;
  logic               visible;
  logic signed [31:0] local_x;
  logic signed [31:0] local_y;

  modport source (output valid, visible, local_x, local_y, input ready);
  modport sink (input valid, visible, local_x, local_y, output ready);
endinterface

>>> hdl/point_visibility_gate_2d_unit.sv
// Pipeline: difference, cordic setup, the cordic iterations (CORDIC_STAGES
// above 24 count as 24), gain multiply, rounding and compare.
// Throughput: one request per cycle; a stalled result holds the whole pipe.
// Reset (synchronous, rst_n low) empties the pipe and loads the register
// defaults: max range all ones, min range zero, field of view pi.
// ----------------------------------------------------------------------------
// point_visibility_gate_2d_unit: landmark visibility test for a 2D robot
// inverse pose transform by rotation cordic, range check, bearing by
// vectoring cordic and field of view check, fully pipelined
// ----------------------------------------------------------------------------
module point_visibility_gate_2d_unit #(
  parameter int COORD_BITS    = 32,
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  pvg_in_if.sink      in_ch,
  pvg_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [62:0] cfg_wdata
);

  localparam int NS = (CORDIC_STAGES > pvg_pkg::TABLE_LEN) ? pvg_pkg::TABLE_LEN
                                                          : CORDIC_STAGES;
  localparam int W  = 44;
  localparam int PW = W + 21;
  localparam int SB = (COORD_BITS > 32) ? 32 : COORD_BITS;
  localparam logic signed [PW-1:0] SAT_HI = (PW'(1) <<< (SB - 1)) - PW'(1);
  localparam logic signed [PW-1:0] SAT_LO = -(PW'(1) <<< (SB - 1));
  localparam logic signed [PW-1:0] ROUND_HALF = PW'(1) <<< (19 + pvg_pkg::GUARD_BITS);

  // configuration registers
  logic [62:0] max_range_sq_r, min_range_sq_r;
  logic [15:0] fov_angle_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_range_sq_r <= pvg_pkg::RANGE_SAT;
      min_range_sq_r <= '0;
      fov_angle_r    <= 16'd32768;
    end else if (cfg_we) begin
      case (cfg_index)
        pvg_pkg::REG_MAX_RANGE_SQ: max_range_sq_r <= cfg_wdata;
        pvg_pkg::REG_MIN_RANGE_SQ: min_range_sq_r <= cfg_wdata;
        pvg_pkg::REG_FOV_ANGLE:    fov_angle_r    <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // global advance: the pipe moves unless a result waits
  logic en;
  logic out_valid_r;
  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // stage a: point minus robot
  logic               a_valid_r, a_pv_r;
  logic signed [32:0] a_dx_r, a_dy_r;
  logic [15:0]        a_hb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) a_valid_r <= 1'b0;
    else if (en) a_valid_r <= in_ch.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_pv_r <= in_ch.pose_valid;
      a_hb_r <= in_ch.robot_heading;
      a_dx_r <= 33'(in_ch.point_x) - 33'(in_ch.robot_x);
      a_dy_r <= 33'(in_ch.point_y) - 33'(in_ch.robot_y);
    end
  end

  // cordic pipeline registers; index k holds the state after k iterations
  logic                valid_r [NS+1];
  logic                pv_r    [NS+1];
  logic                nz_r    [NS+1];
  logic [15:0]         hb_r    [NS+1];
  logic [65:0]         sqx_r   [NS+1];
  logic [65:0]         sqy_r   [NS+1];
  logic signed [W-1:0] rx_r    [NS+1];
  logic signed [W-1:0] ry_r    [NS+1];
  logic [31:0]         rz_r    [NS+1];
  logic signed [W-1:0] vx_r    [NS+1];
  logic signed [W-1:0] vy_r    [NS+1];
  logic [31:0]         vz_r    [NS+1];

  // stage b: squares, quadrant fold of both cordics
  logic signed [W-1:0] b_x, b_y;
  logic [32:0]         b_ax, b_ay;
  logic [31:0]         b_z;

  assign b_x  = {{(W-41){a_dx_r[32]}}, a_dx_r, 8'b0};
  assign b_y  = {{(W-41){a_dy_r[32]}}, a_dy_r, 8'b0};
  assign b_ax = a_dx_r[32] ? 33'(-a_dx_r) : 33'(a_dx_r);
  assign b_ay = a_dy_r[32] ? 33'(-a_dy_r) : 33'(a_dy_r);
  assign b_z  = 32'd0 - {a_hb_r, 16'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r[0] <= 1'b0;
    else if (en) valid_r[0] <= a_valid_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pv_r[0]  <= a_pv_r;
      hb_r[0]  <= a_hb_r;
      nz_r[0]  <= (a_dx_r != '0) || (a_dy_r != '0);
      sqx_r[0] <= 66'(b_ax) * 66'(b_ax);
      sqy_r[0] <= 66'(b_ay) * 66'(b_ay);
      // rotation: fold angles outside +-pi/2 by negating the vector
      if (b_z[31:30] == 2'd1 || b_z[31:30] == 2'd2) begin
        rx_r[0] <= -b_x;
        ry_r[0] <= -b_y;
        rz_r[0] <= b_z + 32'h80000000;
      end else begin
        rx_r[0] <= b_x;
        ry_r[0] <= b_y;
        rz_r[0] <= b_z;
      end
      // vectoring: left half plane starts at pi
      if (a_dx_r[32]) begin
        vx_r[0] <= -b_x;
        vy_r[0] <= -b_y;
        vz_r[0] <= 32'h80000000;
      end else begin
        vx_r[0] <= b_x;
        vy_r[0] <= b_y;
        vz_r[0] <= '0;
      end
    end
  end

  // one cordic iteration of each kind per stage
  for (genvar k = 0; k < NS; k++) begin : g_iter
    localparam logic [31:0] ATAN = pvg_pkg::atan_lut(k);
    logic signed [W-1:0] rxs, rys, vxs, vys;
    assign rxs = rx_r[k] >>> k;
    assign rys = ry_r[k] >>> k;
    assign vxs = vx_r[k] >>> k;
    assign vys = vy_r[k] >>> k;

    always_ff @(posedge clk) begin
      if (!rst_n) valid_r[k+1] <= 1'b0;
      else if (en) valid_r[k+1] <= valid_r[k];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pv_r[k+1]  <= pv_r[k];
        nz_r[k+1]  <= nz_r[k];
        hb_r[k+1]  <= hb_r[k];
        sqx_r[k+1] <= sqx_r[k];
        sqy_r[k+1] <= sqy_r[k];
        if (!rz_r[k][31]) begin
          rx_r[k+1] <= rx_r[k] - rys;
          ry_r[k+1] <= ry_r[k] + rxs;
          rz_r[k+1] <= rz_r[k] - ATAN;
        end else begin
          rx_r[k+1] <= rx_r[k] + rys;
          ry_r[k+1] <= ry_r[k] - rxs;
          rz_r[k+1] <= rz_r[k] + ATAN;
        end
        if (!vy_r[k][W-1]) begin
          vx_r[k+1] <= vx_r[k] + vys;
          vy_r[k+1] <= vy_r[k] - vxs;
          vz_r[k+1] <= vz_r[k] + ATAN;
        end else begin
          vx_r[k+1] <= vx_r[k] - vys;
          vy_r[k+1] <= vy_r[k] + vxs;
          vz_r[k+1] <= vz_r[k] - ATAN;
        end
      end
    end
  end

  // stage m: gain multiply, range sum, bearing
  logic               m_valid_r, m_pv_r;
  logic signed [PW-1:0] m_px_r, m_py_r;
  logic [62:0]        m_r2_r;
  logic [16:0]        m_bear_r;
  logic [66:0]        m_sum;
  logic [31:0]        m_d, m_dr;
  logic [15:0]        m_a16;

  assign m_sum = 67'(sqx_r[NS]) + 67'(sqy_r[NS]);
  assign m_d   = vz_r[NS] - {hb_r[NS], 16'b0};
  assign m_dr  = m_d + 32'h8000;
  assign m_a16 = m_dr[31:16];

  always_ff @(posedge clk) begin
    if (!rst_n) m_valid_r <= 1'b0;
    else if (en) m_valid_r <= valid_r[NS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_pv_r <= pv_r[NS];
      m_px_r <= PW'(rx_r[NS]) * PW'(pvg_pkg::INV_GAIN_Q20);
      m_py_r <= PW'(ry_r[NS]) * PW'(pvg_pkg::INV_GAIN_Q20);
      m_r2_r <= (m_sum > 67'(pvg_pkg::RANGE_SAT)) ? pvg_pkg::RANGE_SAT : m_sum[62:0];
      if (!nz_r[NS])     m_bear_r <= '0;
      else if (m_a16[15]) m_bear_r <= 17'h10000 - 17'(m_a16);
      else               m_bear_r <= 17'(m_a16);
    end
  end

  // stage f: round, saturate, compare
  logic signed [PW-1:0] f_tx, f_ty, f_sx, f_sy;
  logic                 f_vis;

  assign f_tx = (m_px_r + ROUND_HALF) >>> (20 + pvg_pkg::GUARD_BITS);
  assign f_ty = (m_py_r + ROUND_HALF) >>> (20 + pvg_pkg::GUARD_BITS);
  assign f_sx = (f_tx > SAT_HI) ? SAT_HI : ((f_tx < SAT_LO) ? SAT_LO : f_tx);
  assign f_sy = (f_ty > SAT_HI) ? SAT_HI : ((f_ty < SAT_LO) ? SAT_LO : f_ty);
  assign f_vis = m_pv_r && (m_r2_r <= max_range_sq_r) && (m_r2_r >= min_range_sq_r) &&
                 (m_bear_r <= 17'(fov_angle_r));

  logic               out_vis_r;
  logic signed [31:0] out_x_r, out_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= m_valid_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_vis_r <= f_vis;
      out_x_r   <= m_pv_r ? f_sx[31:0] : '0;
      out_y_r   <= m_pv_r ? f_sy[31:0] : '0;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.visible = out_vis_r;
  assign out_ch.local_x = out_x_r;
  assign out_ch.local_y = out_y_r;

endmodule

>>> hdl/pvg_checker.sv
// ----------------------------------------------------------------------------
// pvg_checker: port level checks of the point visibility gate
// result handshake and pipe flow control
// ----------------------------------------------------------------------------
module pvg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_visible,
  input logic [31:0] out_local_x,
  input logic [31:0] out_local_y
);

  // a waiting result stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a waiting result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_visible) && $stable(out_local_x) &&
    $stable(out_local_y))
    else $error("result changed while stalled");

  // an empty output stage never blocks the input
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_valid)
    else $error("result shown right after reset");

endmodule

bind point_visibility_gate_2d_unit pvg_checker u_pvg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_visible(out_ch.visible),
  .out_local_x(out_ch.local_x),
  .out_local_y(out_ch.local_y)
);

>>> tb/point_visibility_gate_2d_unit_tb.sv
// ----------------------------------------------------------------------------
// point_visibility_gate_2d_unit_tb: self-checking bench of the visibility gate
// drives pose/point requests with random gaps and receiver stalls, predicts
// visibility and robot-frame coordinates and compares every result in order
// ----------------------------------------------------------------------------
module point_visibility_gate_2d_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_BITS = 32;
  localparam int CORDIC_STAGES = 16;
  localparam int LATENCY = CORDIC_STAGES + 4;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic               visible;
    logic signed [31:0] local_x;
    logic signed [31:0] local_y;
  } gate_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [62:0] cfg_wdata = '0;

  pvg_in_if in_ch ();
  pvg_out_if out_ch ();

  point_visibility_gate_2d_unit #(
    .COORD_BITS(COORD_BITS), .CORDIC_STAGES(CORDIC_STAGES)
  ) u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // predictor copy of the registers
  logic [62:0] max_range_sq_q;
  logic [62:0] min_range_sq_q;
  logic [15:0] fov_angle_q;

  gate_result_t expected_results[$];
  int fail_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off = 0;
  int idle_cycles = 0;

  initial forever #5 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.pose_valid = 1'b0;
    in_ch.robot_x = '0;
    in_ch.robot_y = '0;
    in_ch.robot_heading = '0;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    out_ch.ready = 1'b0;
  end

  // floor shift right
  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint gain_round(longint v);
    longint p;
    p = v * 64'sd636751;
    return floor_shr(p + (64'sd1 << 27), 28);
  endfunction

  function automatic longint clamp_coord(longint v);
    longint hi, lo;
    hi = (64'sd1 <<< (COORD_BITS - 1)) - 1;
    lo = -(64'sd1 <<< (COORD_BITS - 1));
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v;
  endfunction

  function automatic int stage_total();
    return (CORDIC_STAGES > pvg_pkg::TABLE_LEN) ? pvg_pkg::TABLE_LEN : CORDIC_STAGES;
  endfunction

  // rotate the offset vector into the robot frame
  function automatic void rotate_offset(longint dx, longint dy, bit [31:0] z,
                                        output longint ox, output longint oy);
    longint x, y, xs, ys;
    x = dx * 256;
    y = dy * 256;
    if (z[31:30] == 2'd1 || z[31:30] == 2'd2) begin
      x = -x;
      y = -y;
      z = z + 32'h80000000;
    end
    for (int i = 0; i < stage_total(); i++) begin
      xs = floor_shr(x, i);
      ys = floor_shr(y, i);
      if (!z[31]) begin
        x = x - ys; y = y + xs; z = z - pvg_pkg::atan_lut(i);
      end else begin
        x = x + ys; y = y - xs; z = z + pvg_pkg::atan_lut(i);
      end
    end
    ox = gain_round(x);
    oy = gain_round(y);
  endfunction

  // direction of the offset as 32 bit binary angle
  function automatic bit [31:0] offset_direction(longint dx, longint dy);
    longint x, y, xs, ys;
    bit [31:0] z;
    x = dx * 256;
    y = dy * 256;
    z = '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h80000000;
    end
    for (int i = 0; i < stage_total(); i++) begin
      xs = floor_shr(x, i);
      ys = floor_shr(y, i);
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + pvg_pkg::atan_lut(i);
      end else begin
        x = x - ys; y = y + xs; z = z - pvg_pkg::atan_lut(i);
      end
    end
    return z;
  endfunction

  function automatic gate_result_t predict_visibility(
      bit pose_valid, logic signed [31:0] rx, logic signed [31:0] ry,
      logic signed [15:0] hd, logic signed [31:0] px, logic signed [31:0] py);
    gate_result_t r;
    longint dx, dy, lx, ly;
    logic [63:0] ax, ay, r2;
    bit [31:0] hb, d, dr;
    bit [15:0] a16;
    logic [16:0] bearing;
    r = '0;
    if (pose_valid) begin
      dx = longint'(px) - longint'(rx);
      dy = longint'(py) - longint'(ry);
      hb = {hd, 16'h0};
      rotate_offset(dx, dy, 32'd0 - hb, lx, ly);
      r.local_x = 32'(clamp_coord(lx));
      r.local_y = 32'(clamp_coord(ly));
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      ax = ax * ax;
      ay = ay * ay;
      r2 = (ax > pvg_pkg::RANGE_SAT || ay > pvg_pkg::RANGE_SAT - ax) ?
           {1'b0, pvg_pkg::RANGE_SAT} : ax + ay;
      bearing = '0;
      if (dx != 0 || dy != 0) begin
        d = offset_direction(dx, dy) - hb;
        dr = d + 32'h8000;
        a16 = dr[31:16];
        bearing = a16[15] ? 17'h10000 - a16 : {1'b0, a16};
      end
      r.visible = !(r2 > max_range_sq_q) && !(r2 < min_range_sq_q) &&
                  !(bearing > fov_angle_q);
    end
    return r;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [62:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      pvg_pkg::REG_MAX_RANGE_SQ: max_range_sq_q = value;
      pvg_pkg::REG_MIN_RANGE_SQ: min_range_sq_q = value;
      pvg_pkg::REG_FOV_ANGLE:    fov_angle_q = value[15:0];
      default: ;
    endcase
  endtask

  // send one request, valid held across back-to-back items
  task automatic send_request(bit pv, logic signed [31:0] rx, logic signed [31:0] ry,
                              logic signed [15:0] hd, logic signed [31:0] px,
                              logic signed [31:0] py);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.pose_valid <= pv;
    in_ch.robot_x <= rx;
    in_ch.robot_y <= ry;
    in_ch.robot_heading <= hd;
    in_ch.point_x <= px;
    in_ch.point_y <= py;
    do @(posedge clk); while (!in_ch.ready);
    expected_results.push_back(predict_visibility(pv, rx, ry, hd, px, py));
    @(negedge clk);
  endtask

  task automatic end_burst();
    in_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    end_burst();
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  // mostly short offsets so the range and bearing checks both matter
  task automatic send_random(int scale);
    logic signed [31:0] rx, ry, px, py;
    rx = $urandom;
    ry = $urandom;
    if ($urandom_range(3) == 0) begin
      px = $urandom;
      py = $urandom;
    end else begin
      px = rx + (int'($urandom_range(2 * scale)) - scale);
      py = ry + (int'($urandom_range(2 * scale)) - scale);
    end
    send_request($urandom_range(9) != 0, rx, ry, 16'($urandom), px, py);
  endtask

  task automatic test_directed();
    send_request(1'b0, 32'sd5, 32'sd7, 16'sd100, 32'sd50, 32'sd9);
    send_request(1'b1, 32'sd0, 32'sd0, 16'sd0, 32'sd0, 32'sd0);
    send_request(1'b1, 32'sd1000, -32'sd1000, 16'sh4000, 32'sd1000, -32'sd1000);
    send_request(1'b1, 32'sh80000000, 32'sh80000000, 16'sh8000,
                 32'sh7fffffff, 32'sh7fffffff);
    send_request(1'b1, 32'sh7fffffff, 32'sh7fffffff, 16'sh7fff,
                 32'sh80000000, 32'sh80000000);
    send_request(1'b1, 32'sh7fffffff, 32'sh80000000, 16'sh0000,
                 32'sh80000000, 32'sh7fffffff);
    send_request(1'b1, 32'sd0, 32'sd0, 16'sd0, 32'sd65536, 32'sd0);
    send_request(1'b1, 32'sd0, 32'sd0, 16'sd0, -32'sd65536, 32'sd0);
    send_request(1'b1, 32'sd0, 32'sd0, 16'sd0, 32'sd0, 32'sd65536);
    send_request(1'b1, 32'sd0, 32'sd0, 16'sd0, 32'sd0, -32'sd65536);
    send_request(1'b1, 32'sd0, 32'sd0, 16'sh8000, -32'sd65536, 32'sd1);
    send_request(1'b1, 32'sd0, 32'sd0, 16'sh4000, 32'sd65536, 32'sd65536);
    send_request(1'b1, 32'sd0, 32'sd0, 16'shc000, 32'sd1, -32'sd1);
    send_request(1'b1, 32'sd0, 32'sd0, 16'sh2000, -32'sd1, -32'sd1);
    drain();
    // tight limits: exact range equality and narrow view
    write_reg(pvg_pkg::REG_MAX_RANGE_SQ, 63'h1_0000_0000);
    write_reg(pvg_pkg::REG_MIN_RANGE_SQ, 63'h1_0000_0000);
    write_reg(pvg_pkg::REG_FOV_ANGLE, 63'd0);
    send_request(1'b1, 32'sd0, 32'sd0, 16'sd0, 32'sd65536, 32'sd0);
    send_request(1'b1, 32'sd0, 32'sd0, 16'sd0, 32'sd65537, 32'sd0);
    send_request(1'b1, 32'sd0, 32'sd0, 16'sd0, 32'sd65535, 32'sd0);
    send_request(1'b1, 32'sd0, 32'sd0, 16'sd0, 32'sd0, 32'sd65536);
    drain();
    write_reg(pvg_pkg::REG_MAX_RANGE_SQ, pvg_pkg::RANGE_SAT);
    write_reg(pvg_pkg::REG_MIN_RANGE_SQ, pvg_pkg::RANGE_SAT);
    write_reg(pvg_pkg::REG_FOV_ANGLE, 63'hffff);
    send_request(1'b1, 32'sh80000000, 32'sh80000000, 16'sd0,
                 32'sh7fffffff, 32'sh7fffffff);
    send_request(1'b1, 32'sd0, 32'sd0, 16'sd0, 32'sd3, 32'sd0);
    drain();
  endtask

  task automatic test_random_phase(int count, logic [62:0] mx, logic [62:0] mn,
                                   logic [15:0] fov, int scale);
    repeat (LATENCY) @(negedge clk);
    write_reg(pvg_pkg::REG_MAX_RANGE_SQ, mx);
    write_reg(pvg_pkg::REG_MIN_RANGE_SQ, mn);
    write_reg(pvg_pkg::REG_FOV_ANGLE, 63'(fov));
    repeat (count) send_random(scale);
    drain();
  endtask

  // long receiver hold-off while requests keep coming
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off = 200;
    repeat (80) send_random(1 << 20);
    drain();
  endtask

  // receiver side: ready with random stalls and optional long hold-off
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result check against the oldest prediction
  always @(posedge clk) begin
    gate_result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result visible=%0b", out_ch.visible);
        fail_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_ch.visible !== exp_r.visible) begin
          $error("visible expected %0b actual %0b", exp_r.visible, out_ch.visible);
          fail_count++;
        end
        if (out_ch.local_x !== exp_r.local_x) begin
          $error("local_x expected %0d actual %0d", exp_r.local_x, out_ch.local_x);
          fail_count++;
        end
        if (out_ch.local_y !== exp_r.local_y) begin
          $error("local_y expected %0d actual %0d", exp_r.local_y, out_ch.local_y);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted request or result
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("point_visibility_gate_2d_unit: mismatch");
        $finish;
      end
    end
  end

  initial begin
    max_range_sq_q = pvg_pkg::RANGE_SAT;
    min_range_sq_q = '0;
    fov_angle_q = 16'd32768;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    send_idle_pct = 27;
    recv_idle_pct = 73;
    test_directed();
    test_random_phase(300, pvg_pkg::RANGE_SAT, '0, 16'd32768, 1 << 24);
    send_idle_pct = 73;
    recv_idle_pct = 27;
    test_random_phase(300, 63'h0000_0100_0000_0000, 63'h0000_0001_0000_0000,
                      16'd8192, 1 << 22);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_phase(300, 63'h0000_0040_0000_0000, '0, 16'd16384, 1 << 21);
    test_random_phase(300, pvg_pkg::RANGE_SAT, 63'h0000_0000_0100_0000, 16'd1000,
                      1 << 18);
    test_backpressure();
    end_burst();
    repeat (LATENCY + 10) @(negedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("point_visibility_gate_2d_unit: match");
    end else begin
      $display("point_visibility_gate_2d_unit: mismatch");
    end
    $finish;
  end

endmodule
